// ===== rtl/flptw_pkg.sv =====
// Shared types and constants for the four-level page table walker.
// No dependencies; every other file of the block but flptw_ram refers to this package.
package flptw_pkg;

   localparam int WORDS_PER_TABLE = 512;
   localparam int INDEX_BITS      = 9;
   localparam int PHYS_BITS       = 52;
   localparam int VIRT_BITS       = 48;
   localparam int PAGE_NUM_BITS   = 40;

   localparam int BIT_PRESENT = 0;
   localparam int BIT_WRITE   = 1;
   localparam int BIT_HUGE    = 7;
   localparam int BIT_DEVICE  = 9;
   localparam int BIT_NOEXEC  = 63;

   typedef enum logic [1:0] {
      CMD_WRITE     = 2'd0,
      CMD_TRANSLATE = 2'd1,
      CMD_UNMAP     = 2'd2,
      CMD_PROTECT   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_UNMAPPED = 2'd1,
      ST_OUTSIDE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SIZE_4K = 2'd0,
      SIZE_2M = 2'd1,
      SIZE_1G = 2'd2
   } size_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_WB,
      S_DONE
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic accept;
      logic walk;
      logic wb;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic acc_done;
      logic walk_done;
      logic walk_wb;
   } ctrl_status_type;

   function automatic logic [INDEX_BITS-1:0] level_index(
      input logic [VIRT_BITS-1:0] va,
      input logic [1:0]           level
   );
      logic [INDEX_BITS-1:0] idx;
      unique case (level)
         2'd3:    idx = va[47:39];
         2'd2:    idx = va[38:30];
         2'd1:    idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

endpackage

// ===== rtl/four_level_page_table_walker.sv =====
// Four-level page table walker with a private table store of TABLE_PAGES
// pages. After reset the block clears every word of the store and takes no
// request until the clearing pass is done. A write command, or a walk whose
// root page lies outside the store, goes from accept straight to the result
// load. A walk reads one table word per cycle from the single-port table
// RAM, one level after another, so a full translate runs through accept,
// four level reads and result load; unmap and protect add a write-back step
// for the leaf. A walk that stops early is shorter by the levels it skips.
// Results sit in an output register, one beat per request.
// Depends on flptw_pkg, flptw_ctrl and flptw_datapath.
module four_level_page_table_walker #(
   parameter int TABLE_PAGES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [51:0] req_root_addr,
   input  logic [47:0] req_virt_addr,
   input  logic [11:0] req_word_index,
   input  logic [63:0] req_word_data,
   input  logic        req_prot_write,
   input  logic        req_prot_nx,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [51:0] rsp_phys_addr,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_page_size
);

   flptw_pkg::ctrl_cmd_type    ctrl_cmd;
   flptw_pkg::ctrl_status_type ctrl_status;

   flptw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   flptw_datapath #(.TABLE_PAGES(TABLE_PAGES)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctrl_cmd),
      .status         (ctrl_status),
      .req_cmd        (req_cmd),
      .req_root_addr  (req_root_addr),
      .req_virt_addr  (req_virt_addr),
      .req_word_index (req_word_index),
      .req_word_data  (req_word_data),
      .req_prot_write (req_prot_write),
      .req_prot_nx    (req_prot_nx),
      .rsp_phys_addr  (rsp_phys_addr),
      .rsp_status     (rsp_status),
      .rsp_page_size  (rsp_page_size)
   );

endmodule

// ===== rtl/flptw_ram.sv =====
// Generic single-port RAM with registered read data (read-first).
// No dependencies.
module flptw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/flptw_ctrl.sv =====
// Controller state machine of the page table walker: clear pass, accept,
// level walk, write-back and result hand-off. Depends on flptw_pkg.
module flptw_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  flptw_pkg::ctrl_status_type status,
   output flptw_pkg::ctrl_cmd_type    cmd
);

   flptw_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         flptw_pkg::S_CLEAR: begin
            if (status.clr_last) state_in = flptw_pkg::S_IDLE;
         end
         flptw_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = status.acc_done ? flptw_pkg::S_DONE : flptw_pkg::S_WALK;
            end
         end
         flptw_pkg::S_WALK: begin
            if (status.walk_wb) begin
               state_in = flptw_pkg::S_WB;
            end else if (status.walk_done) begin
               state_in = flptw_pkg::S_DONE;
            end
         end
         flptw_pkg::S_WB: begin
            state_in = flptw_pkg::S_DONE;
         end
         flptw_pkg::S_DONE: begin
            if (out_free) state_in = flptw_pkg::S_IDLE;
         end
         default: state_in = flptw_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         flptw_pkg::S_CLEAR: cmd.clr_step = 1'b1;
         flptw_pkg::S_IDLE:  cmd.accept   = req_valid;
         flptw_pkg::S_WALK:  cmd.walk     = 1'b1;
         flptw_pkg::S_WB:    cmd.wb       = 1'b1;
         flptw_pkg::S_DONE:  cmd.rsp_load = out_free;
         default:            cmd          = '0;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flptw_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == flptw_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken beat");

   a_wb_after_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == flptw_pkg::S_WB) |-> ($past(state_ff) == flptw_pkg::S_WALK))
      else $error("write-back without a preceding walk");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == flptw_pkg::S_DONE))
      else $error("result beat raised outside the done state");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == flptw_pkg::S_CLEAR) |=> !$past(cmd.accept))
      else $error("item accepted during the clearing pass");

endmodule

// ===== rtl/flptw_datapath.sv =====
// Datapath of the page table walker: table RAM, walk registers, entry
// evaluation and result registers. Depends on flptw_pkg and flptw_ram.
module flptw_datapath #(
   parameter int TABLE_PAGES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  flptw_pkg::ctrl_cmd_type    cmd,
   output flptw_pkg::ctrl_status_type status,
   input  logic [1:0]                 req_cmd,
   input  logic [51:0]                req_root_addr,
   input  logic [47:0]                req_virt_addr,
   input  logic [11:0]                req_word_index,
   input  logic [63:0]                req_word_data,
   input  logic                       req_prot_write,
   input  logic                       req_prot_nx,
   output logic [51:0]                rsp_phys_addr,
   output logic [1:0]                 rsp_status,
   output logic [1:0]                 rsp_page_size
);

   localparam int DEPTH = TABLE_PAGES * flptw_pkg::WORDS_PER_TABLE;
   localparam int PW    = $clog2(TABLE_PAGES);
   localparam int AW    = PW + flptw_pkg::INDEX_BITS;
   localparam int NPB   = flptw_pkg::PAGE_NUM_BITS;

   logic [1:0]    cmd_ff;
   logic [47:0]   va_ff;
   logic          pw_ff, pnx_ff;
   logic [1:0]    level_ff;
   logic [AW-1:0] slot_ff, clr_cnt_ff, clr_cnt_in;
   logic [63:0]   wb_data_ff;
   logic [51:0]   res_pa_ff, res_pa_in;
   logic [1:0]    res_st_ff, res_st_in, res_size_ff, res_size_in;
   logic [51:0]   rsp_pa_ff;
   logic [1:0]    rsp_st_ff, rsp_size_ff;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [63:0]   ram_wdata, entry;

   logic [31:0]    widx_wide;
   logic           widx_in;
   logic [NPB-1:0] root_page, next_page;
   logic           root_in, next_in;
   logic [AW-1:0]  root_slot, next_slot;
   logic           is_write;

   logic        eval_done, eval_wb;
   logic [51:0] eval_pa;
   logic [1:0]  eval_st, eval_size;
   logic [63:0] eval_wb_data;

   flptw_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (entry)
   );

   assign widx_wide = 32'(req_word_index);
   assign widx_in   = widx_wide < 32'(DEPTH);
   assign root_page = req_root_addr[51:12];
   assign root_in   = root_page < NPB'(TABLE_PAGES);
   assign root_slot = {root_page[PW-1:0], flptw_pkg::level_index(req_virt_addr, 2'd3)};
   assign is_write  = (req_cmd == flptw_pkg::CMD_WRITE);

   assign next_page = entry[51:12];
   assign next_in   = next_page < NPB'(TABLE_PAGES);
   assign next_slot = {next_page[PW-1:0], flptw_pkg::level_index(va_ff, level_ff - 2'd1)};

   // Evaluate the entry read for the current level.
   always_comb begin
      eval_done    = 1'b1;
      eval_wb      = 1'b0;
      eval_pa      = '0;
      eval_st      = flptw_pkg::ST_OK;
      eval_size    = flptw_pkg::SIZE_4K;
      eval_wb_data = '0;
      if (!entry[flptw_pkg::BIT_PRESENT]) begin
         eval_st = flptw_pkg::ST_UNMAPPED;
      end else if (level_ff == 2'd0) begin
         case (cmd_ff)
            flptw_pkg::CMD_TRANSLATE: begin
               eval_pa = {entry[51:12], va_ff[11:0]};
            end
            flptw_pkg::CMD_UNMAP: begin
               eval_wb = 1'b1;
               if (!entry[flptw_pkg::BIT_DEVICE]) eval_pa = {entry[51:12], 12'd0};
            end
            default: begin
               eval_wb      = 1'b1;
               eval_wb_data = {pnx_ff, entry[62:2], pw_ff, entry[0]};
            end
         endcase
      end else if (entry[flptw_pkg::BIT_HUGE]) begin
         if (level_ff == 2'd3 || cmd_ff != flptw_pkg::CMD_TRANSLATE) begin
            eval_st = flptw_pkg::ST_UNMAPPED;
         end else if (level_ff == 2'd2) begin
            eval_pa   = {entry[51:30], va_ff[29:0]};
            eval_size = flptw_pkg::SIZE_1G;
         end else begin
            eval_pa   = {entry[51:21], va_ff[20:0]};
            eval_size = flptw_pkg::SIZE_2M;
         end
      end else if (!next_in) begin
         eval_st = flptw_pkg::ST_OUTSIDE;
      end else begin
         eval_done = 1'b0;
      end
   end

   assign status.clr_last  = (clr_cnt_ff == AW'(DEPTH - 1));
   assign status.acc_done  = is_write || !root_in;
   assign status.walk_done = eval_done;
   assign status.walk_wb   = eval_wb;

   // Table port: clear, command write, root or walk read, or leaf write-back.
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = slot_ff;
      ram_wdata = '0;
      if (cmd.clr_step) begin
         ram_we   = 1'b1;
         ram_addr = clr_cnt_ff;
      end else if (cmd.accept) begin
         if (is_write) begin
            ram_we    = widx_in;
            ram_addr  = widx_wide[AW-1:0];
            ram_wdata = req_word_data;
         end else begin
            ram_addr = root_slot;
         end
      end else if (cmd.walk) begin
         ram_addr = next_slot;
      end else if (cmd.wb) begin
         ram_we    = 1'b1;
         ram_wdata = wb_data_ff;
      end
   end

   always_comb begin
      res_pa_in   = res_pa_ff;
      res_st_in   = res_st_ff;
      res_size_in = res_size_ff;
      if (cmd.accept) begin
         res_pa_in   = '0;
         res_size_in = flptw_pkg::SIZE_4K;
         res_st_in   = (is_write && widx_in) ? flptw_pkg::ST_OK : flptw_pkg::ST_OUTSIDE;
      end else if (cmd.walk && eval_done) begin
         res_pa_in   = eval_pa;
         res_st_in   = eval_st;
         res_size_in = eval_size;
      end
   end

   assign clr_cnt_in = cmd.clr_step ? clr_cnt_ff + AW'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      res_pa_ff   <= res_pa_in;
      res_st_ff   <= res_st_in;
      res_size_ff <= res_size_in;
      if (cmd.accept) begin
         cmd_ff   <= req_cmd;
         va_ff    <= req_virt_addr;
         pw_ff    <= req_prot_write;
         pnx_ff   <= req_prot_nx;
         level_ff <= 2'd3;
      end else if (cmd.walk) begin
         level_ff <= level_ff - 2'd1;
      end
      // hold the leaf slot for the write-back
      if (cmd.accept || (cmd.walk && !eval_done)) begin
         slot_ff <= ram_addr;
      end
      if (cmd.walk) begin
         wb_data_ff <= eval_wb_data;
      end
      if (cmd.rsp_load) begin
         rsp_pa_ff   <= res_pa_ff;
         rsp_st_ff   <= res_st_ff;
         rsp_size_ff <= res_size_ff;
      end
   end

   assign rsp_phys_addr = rsp_pa_ff;
   assign rsp_status    = rsp_st_ff;
   assign rsp_page_size = rsp_size_ff;

   a_wb_at_leaf: assert property (@(posedge clock) disable iff (reset)
      cmd.wb |-> (level_ff == 2'd3 &&
                  (cmd_ff == flptw_pkg::CMD_UNMAP || cmd_ff == flptw_pkg::CMD_PROTECT)))
      else $error("write-back away from a leaf of unmap or protect");

endmodule

// ===== bench/flptw_checker.sv =====
// Scoreboard for the four-level page table walker: keeps a shadow table store,
// predicts one response per accepted request beat and compares them in order.
// Depends on flptw_pkg.
`timescale 1ns / 1ps
module flptw_checker #(
   parameter int TABLE_PAGES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [51:0] req_root_addr,
   input  logic [47:0] req_virt_addr,
   input  logic [11:0] req_word_index,
   input  logic [63:0] req_word_data,
   input  logic        req_prot_write,
   input  logic        req_prot_nx,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [51:0] rsp_phys_addr,
   input  logic [1:0]  rsp_status,
   input  logic [1:0]  rsp_page_size,
   output int          fail_count,
   output int          open_count,
   output int          rsp_count,
   output int          walk_ok_count,
   output int          huge_count
);

   localparam int STORE_WORDS = TABLE_PAGES * flptw_pkg::WORDS_PER_TABLE;

   typedef struct packed {
      logic [51:0]           phys;
      flptw_pkg::status_type status;
      flptw_pkg::size_type   size;
   } walk_result_type;

   logic [63:0]     shadow_words [STORE_WORDS];
   walk_result_type pending_responses [$];

   function automatic int table_slot(input logic [51:0] table_addr, input logic [47:0] va,
                                     input int lvl);
      logic [39:0] page;
      page = table_addr[51:12];
      if (page >= 40'(TABLE_PAGES)) return -1;
      return int'(page) * flptw_pkg::WORDS_PER_TABLE + int'(va[12 + 9 * lvl +: 9]);
   endfunction

   function automatic walk_result_type walk_translate(input logic [51:0] root,
                                                      input logic [47:0] va);
      walk_result_type r;
      logic [51:0]     ta;
      logic [63:0]     e;
      int              slot;
      int              lvl;
      r.phys = '0;
      r.status = flptw_pkg::ST_OK;
      r.size = flptw_pkg::SIZE_4K;
      ta = {root[51:12], 12'h000};
      for (lvl = 3; lvl >= 0; lvl--) begin
         slot = table_slot(ta, va, lvl);
         if (slot < 0) begin
            r.status = flptw_pkg::ST_OUTSIDE;
            return r;
         end
         e = shadow_words[slot];
         if (!e[flptw_pkg::BIT_PRESENT] || (lvl == 3 && e[flptw_pkg::BIT_HUGE])) begin
            r.status = flptw_pkg::ST_UNMAPPED;
            return r;
         end
         if (lvl == 0) begin
            r.phys = {e[51:12], va[11:0]};
            return r;
         end
         if (e[flptw_pkg::BIT_HUGE]) begin
            if (lvl == 1) begin
               r.size = flptw_pkg::SIZE_2M;
               r.phys = {e[51:21], va[20:0]};
            end else begin
               r.size = flptw_pkg::SIZE_1G;
               r.phys = {e[51:30], va[29:0]};
            end
            return r;
         end
         ta = {e[51:12], 12'h000};
      end
      return r;
   endfunction

   function automatic walk_result_type walk_edit_leaf(input flptw_pkg::cmd_type cmd,
                                                      input logic [51:0] root,
                                                      input logic [47:0] va, input logic pw,
                                                      input logic pnx);
      walk_result_type r;
      logic [51:0]     ta;
      logic [63:0]     e;
      int              slot;
      int              lvl;
      r.phys = '0;
      r.status = flptw_pkg::ST_OK;
      r.size = flptw_pkg::SIZE_4K;
      ta = {root[51:12], 12'h000};
      for (lvl = 3; lvl >= 1; lvl--) begin
         slot = table_slot(ta, va, lvl);
         if (slot < 0) begin
            r.status = flptw_pkg::ST_OUTSIDE;
            return r;
         end
         e = shadow_words[slot];
         if (!e[flptw_pkg::BIT_PRESENT] || e[flptw_pkg::BIT_HUGE]) begin
            r.status = flptw_pkg::ST_UNMAPPED;
            return r;
         end
         ta = {e[51:12], 12'h000};
      end
      slot = table_slot(ta, va, 0);
      if (slot < 0) begin
         r.status = flptw_pkg::ST_OUTSIDE;
         return r;
      end
      e = shadow_words[slot];
      if (!e[flptw_pkg::BIT_PRESENT]) begin
         r.status = flptw_pkg::ST_UNMAPPED;
      end else if (cmd == flptw_pkg::CMD_UNMAP) begin
         if (!e[flptw_pkg::BIT_DEVICE]) r.phys = {e[51:12], 12'h000};
         shadow_words[slot] = '0;
      end else begin
         e[flptw_pkg::BIT_WRITE] = pw;
         e[flptw_pkg::BIT_NOEXEC] = pnx;
         shadow_words[slot] = e;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      walk_result_type want;
      walk_result_type seen;
      int              i;
      if (reset) begin
         for (i = 0; i < STORE_WORDS; i++) shadow_words[i] = '0;
         pending_responses.delete();
         fail_count = 0;
         rsp_count = 0;
         walk_ok_count = 0;
         huge_count = 0;
      end else begin
         // retire the response first: a beat arriving now belongs to an older request
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            seen.phys = rsp_phys_addr;
            seen.status = flptw_pkg::status_type'(rsp_status);
            seen.size = flptw_pkg::size_type'(rsp_page_size);
            if (pending_responses.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: beat with nothing outstanding: phys %h status %0d size %0d",
                           $time, rsp_phys_addr, rsp_status, rsp_page_size);
            end else begin
               want = pending_responses.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch: expected phys %h status %0d size %0d, ",
                               "got phys %h status %0d size %0d"},
                              $time, want.phys, want.status, want.size,
                              rsp_phys_addr, rsp_status, rsp_page_size);
               end
            end
         end
         if (req_valid && req_ready) begin
            case (flptw_pkg::cmd_type'(req_cmd))
               flptw_pkg::CMD_WRITE: begin
                  want.phys = '0;
                  want.status = flptw_pkg::ST_OK;
                  want.size = flptw_pkg::SIZE_4K;
                  if (int'(req_word_index) < STORE_WORDS)
                     shadow_words[req_word_index] = req_word_data;
                  else
                     want.status = flptw_pkg::ST_OUTSIDE;
               end
               flptw_pkg::CMD_TRANSLATE: begin
                  want = walk_translate(req_root_addr, req_virt_addr);
                  if (want.status == flptw_pkg::ST_OK) begin
                     walk_ok_count++;
                     if (want.size != flptw_pkg::SIZE_4K) huge_count++;
                  end
               end
               default: begin
                  want = walk_edit_leaf(flptw_pkg::cmd_type'(req_cmd), req_root_addr,
                                        req_virt_addr, req_prot_write, req_prot_nx);
               end
            endcase
            pending_responses.push_back(want);
         end
      end
      open_count = pending_responses.size();
   end

endmodule

// ===== bench/four_level_page_table_walker_test.sv =====
// Top of the page table walker testbench: clock, reset, request and response
// traffic, verdict. Depends on flptw_pkg, flptw_checker and the walker RTL.
`timescale 1ns / 1ps
module four_level_page_table_walker_test;

   localparam int PAGES = 8;
   localparam int RANDOM_BEATS = 1400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [51:0] req_root_addr;
   logic [47:0] req_virt_addr;
   logic [11:0] req_word_index;
   logic [63:0] req_word_data;
   logic        req_prot_write;
   logic        req_prot_nx;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [51:0] rsp_phys_addr;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_page_size;

   int          fail_count;
   int          open_count;
   int          rsp_count;
   int          walk_ok_count;
   int          huge_count;

   int          beats_sent;
   int          cmd_beats [4];
   bit          quiet;
   logic [47:0] recent_va [8];

   four_level_page_table_walker #(
      .TABLE_PAGES(PAGES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_root_addr(req_root_addr),
      .req_virt_addr(req_virt_addr),
      .req_word_index(req_word_index),
      .req_word_data(req_word_data),
      .req_prot_write(req_prot_write),
      .req_prot_nx(req_prot_nx),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_phys_addr(rsp_phys_addr),
      .rsp_status(rsp_status),
      .rsp_page_size(rsp_page_size)
   );

   flptw_checker #(
      .TABLE_PAGES(PAGES)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_root_addr(req_root_addr),
      .req_virt_addr(req_virt_addr),
      .req_word_index(req_word_index),
      .req_word_data(req_word_data),
      .req_prot_write(req_prot_write),
      .req_prot_nx(req_prot_nx),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_phys_addr(rsp_phys_addr),
      .rsp_status(rsp_status),
      .rsp_page_size(rsp_page_size),
      .fail_count(fail_count),
      .open_count(open_count),
      .rsp_count(rsp_count),
      .walk_ok_count(walk_ok_count),
      .huge_count(huge_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_beat(input flptw_pkg::cmd_type cmd, input logic [51:0] root,
                            input logic [47:0] va, input logic [11:0] widx,
                            input logic [63:0] data, input logic pw, input logic pnx);
      while (!quiet && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_root_addr <= root;
      req_virt_addr <= va;
      req_word_index <= widx;
      req_word_data <= data;
      req_prot_write <= pw;
      req_prot_nx <= pnx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      cmd_beats[int'(cmd)]++;
      @(negedge clock);
   endtask

   task automatic write_word(input logic [11:0] widx, input logic [63:0] data);
      send_beat(flptw_pkg::CMD_WRITE, 52'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                widx, data, 1'($urandom), 1'($urandom));
   endtask

   task automatic put_entry(input int page, input logic [8:0] idx, input logic [63:0] e);
      write_word(12'(page * flptw_pkg::WORDS_PER_TABLE + idx), e);
   endtask

   task automatic walk_op(input flptw_pkg::cmd_type cmd, input logic [51:0] root,
                          input logic [47:0] va);
      send_beat(cmd, root, va, 12'($urandom), {$urandom, $urandom}, 1'($urandom),
                1'($urandom));
   endtask

   function automatic logic [51:0] table_addr(input logic [39:0] page);
      return {page, 12'($urandom)};
   endfunction

   function automatic logic [63:0] entry_word(input logic [39:0] frame, input logic huge,
                                              input logic device);
      logic [63:0] e;
      e = {$urandom, $urandom};
      e[51:12] = frame;
      e[flptw_pkg::BIT_PRESENT] = 1'b1;
      e[flptw_pkg::BIT_HUGE] = huge;
      e[flptw_pkg::BIT_DEVICE] = device;
      return e;
   endfunction

   function automatic flptw_pkg::cmd_type pick_walk_cmd();
      int r;
      r = $urandom_range(3);
      if (r < 2) return flptw_pkg::CMD_TRANSLATE;
      if (r == 2) return flptw_pkg::CMD_UNMAP;
      return flptw_pkg::CMD_PROTECT;
   endfunction

   // build one mapping, leaf at a random level, then walk it a few times
   task automatic map_and_use();
      logic [47:0] va;
      logic [63:0] e;
      int          pg [4];
      int          leaf_lvl;
      int          lvl;
      int          r;
      int          k;
      va = 48'({$urandom, $urandom});
      pg[3] = $urandom_range(0, 1);
      pg[2] = $urandom_range(2, 3);
      pg[1] = $urandom_range(4, 5);
      pg[0] = $urandom_range(6, 7);
      if ($urandom_range(9) == 0) pg[$urandom_range(0, 3)] = $urandom_range(PAGES, PAGES + 3);
      r = $urandom_range(99);
      leaf_lvl = (r < 4) ? 3 : (r < 16) ? 2 : (r < 30) ? 1 : 0;
      for (lvl = 3; lvl >= leaf_lvl; lvl--) begin
         if (pg[lvl] >= PAGES) break;
         if (lvl == leaf_lvl)
            e = entry_word(40'({$urandom, $urandom}), (lvl != 0) || 1'($urandom),
                           $urandom_range(3) == 0);
         else
            e = entry_word(40'(pg[lvl - 1]), 1'b0, 1'($urandom));
         if (lvl == leaf_lvl && $urandom_range(9) == 0) e[flptw_pkg::BIT_PRESENT] = 1'b0;
         put_entry(pg[lvl], va[12 + 9 * lvl +: 9], e);
      end
      for (k = $urandom_range(1, 3); k > 0; k--) begin
         va[11:0] = 12'($urandom);
         if (leaf_lvl >= 1) va[20:12] = 9'($urandom);
         if (leaf_lvl >= 2) va[29:21] = 9'($urandom);
         walk_op(pick_walk_cmd(), table_addr(40'(pg[3])), va);
      end
      recent_va[$urandom_range(7)] = va;
   endtask

   initial begin
      int          hold;
      int          holdoff_done;
      rsp_ready = 1'b0;
      holdoff_done = 0;
      forever begin
         @(negedge clock);
         if (!holdoff_done && beats_sent >= 400) begin
            rsp_ready <= 1'b0;
            for (hold = 0; hold < 300; hold++) @(negedge clock);
            holdoff_done = 1;
         end
         rsp_ready <= quiet || ($urandom_range(99) >= 6);
      end
   end

   initial begin
      logic [47:0] va_top;
      logic [47:0] va;
      logic [51:0] root;
      int          start;
      int          pick;
      int          i;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = '0;
      req_root_addr = '0;
      req_virt_addr = '0;
      req_word_index = '0;
      req_word_data = '0;
      req_prot_write = 1'b0;
      req_prot_nx = 1'b0;
      quiet = 1'b0;
      beats_sent = 0;
      for (i = 0; i < 4; i++) cmd_beats[i] = 0;
      for (i = 0; i < 8; i++) recent_va[i] = 48'({$urandom, $urandom});
      va_top = '1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store, reserved huge bit at the top, tables outside the store
      walk_op(flptw_pkg::CMD_TRANSLATE, '0, '0);
      put_entry(0, 9'd0, '1);
      walk_op(flptw_pkg::CMD_TRANSLATE, table_addr(40'd0), '0);
      walk_op(flptw_pkg::CMD_UNMAP, table_addr(40'd0), '0);
      write_word(12'hFFF, '0);
      walk_op(flptw_pkg::CMD_TRANSLATE, '1, va_top);
      walk_op(flptw_pkg::CMD_PROTECT, table_addr(40'(PAGES)), va_top);

      // full 4 KiB chain on the top index of every level
      put_entry(0, 9'h1FF, entry_word(40'd1, 1'b0, 1'b0));
      put_entry(1, 9'h1FF, entry_word(40'd2, 1'b0, 1'b0));
      put_entry(2, 9'h1FF, entry_word(40'd3, 1'b0, 1'b0));
      put_entry(3, 9'h1FF, entry_word('1, 1'b0, 1'b0));
      walk_op(flptw_pkg::CMD_TRANSLATE, table_addr(40'd0), va_top);
      send_beat(flptw_pkg::CMD_PROTECT, table_addr(40'd0), va_top, '0, '0, 1'b0, 1'b0);
      send_beat(flptw_pkg::CMD_PROTECT, table_addr(40'd0), va_top, '1, '1, 1'b1, 1'b1);
      walk_op(flptw_pkg::CMD_UNMAP, table_addr(40'd0), va_top);
      walk_op(flptw_pkg::CMD_TRANSLATE, table_addr(40'd0), va_top);

      // device leaf, then 2 MiB and 1 GiB leaves
      put_entry(3, 9'h1FF, entry_word(40'h5A_5A5A_5A5A, 1'b0, 1'b1));
      walk_op(flptw_pkg::CMD_UNMAP, table_addr(40'd0), va_top);
      put_entry(2, 9'h1FF, entry_word(40'hA5_A5A5_A5A5, 1'b1, 1'b0));
      walk_op(flptw_pkg::CMD_TRANSLATE, table_addr(40'd0), va_top);
      walk_op(flptw_pkg::CMD_UNMAP, table_addr(40'd0), va_top);
      put_entry(1, 9'h1FF, entry_word('1, 1'b1, 1'b0));
      walk_op(flptw_pkg::CMD_TRANSLATE, table_addr(40'd0), va_top);
      walk_op(flptw_pkg::CMD_PROTECT, table_addr(40'd0), va_top);

      // next table and leaf table beyond the store
      put_entry(1, 9'h1FF, entry_word(40'(PAGES), 1'b0, 1'b0));
      walk_op(flptw_pkg::CMD_TRANSLATE, table_addr(40'd0), va_top);
      put_entry(1, 9'h1FF, entry_word(40'd2, 1'b0, 1'b0));
      put_entry(2, 9'h1FF, entry_word(40'(PAGES + 1), 1'b0, 1'b0));
      walk_op(flptw_pkg::CMD_UNMAP, table_addr(40'd0), va_top);

      start = beats_sent;
      while (beats_sent < start + RANDOM_BEATS) begin
         quiet = (beats_sent >= start + 500) && (beats_sent < start + 800);
         pick = $urandom_range(99);
         if (pick < 55) begin
            map_and_use();
         end else if (pick < 75) begin
            va = recent_va[$urandom_range(7)];
            va[11:0] = 12'($urandom);
            walk_op(pick_walk_cmd(), table_addr(40'($urandom_range(0, 1))), va);
         end else if (pick < 88) begin
            if ($urandom_range(1) == 1)
               root = 52'({$urandom, $urandom});
            else
               root = table_addr(40'($urandom_range(0, PAGES - 1)));
            walk_op(flptw_pkg::cmd_type'($urandom_range(1, 3)), root,
                    48'({$urandom, $urandom}));
         end else begin
            write_word(12'($urandom), {$urandom, $urandom});
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (open_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("sent %0d request beats: %0d writes, %0d translates, %0d unmaps, %0d protects",
               beats_sent, cmd_beats[0], cmd_beats[1], cmd_beats[2], cmd_beats[3]);
      $display("checked %0d response beats; %0d walks reached a page, %0d of them huge",
               rsp_count, walk_ok_count, huge_count);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/flptw_pkg.sv
rtl/flptw_ram.sv
rtl/flptw_ctrl.sv
rtl/flptw_datapath.sv
rtl/four_level_page_table_walker.sv
bench/flptw_checker.sv
bench/four_level_page_table_walker_test.sv
